>>> rtl/core/ffca_pkg.sv
// ffca_pkg: shared types and constants of the first-fit coalescing allocator
// no dependencies
package ffca_pkg;

  localparam int FUNC_W   = 1;
  localparam int ADDR_W   = 20;
  localparam int SIZE_W   = 21;
  localparam int STATUS_W = 2;

  // address span of the pool, in bits
  localparam int ADDR_BITS = 20;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // one request after rounding, as the engine sees it
  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W+1:0] size;
  } req_t;

  // one result item
  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] alloc_address;
    logic [SIZE_W-1:0] free_bytes;
  } rsp_t;

endpackage

>>> rtl/core/ffca_ram.sv
// ffca_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ffca_engine.sv
// ffca_engine: sequencer that scans, shifts and rewrites the segment table
// depends on ffca_pkg and ffca_ram
module ffca_engine #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  output logic                          cfg_ready,
  input  logic [ffca_pkg::SIZE_W-1:0]   cfg_pool,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  ffca_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output ffca_pkg::rsp_t                rsp
);
  import ffca_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = ADDR_BITS + 2;
  localparam int WW = EW + EW;
  localparam logic [EW-1:0] SPAN = EW'(1) << ADDR_BITS;
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_SCAN  = 8'b00000100,
    S_PREV  = 8'b00001000,
    S_DEC   = 8'b00010000,
    S_SHIFT = 8'b00100000,
    S_WRITE = 8'b01000000,
    S_RESP  = 8'b10000000
  } state_t;

  state_t          state;
  logic [EW-1:0]   pool;
  logic [CW-1:0]   count;
  logic [EW-1:0]   total;
  req_t            cur;
  logic [CW-1:0]   idx;
  logic [EW-1:0]   prev_start;
  logic [EW-1:0]   prev_len;
  logic            prev_ok;
  logic [EW-1:0]   nxt_start;
  logic [EW-1:0]   nxt_len;
  logic            shift_up;
  logic [CW-1:0]   sidx;
  logic [WW-1:0]   fin_data;
  logic            add_count;
  logic            need_clear;
  status_t         r_status;
  logic [ADDR_W-1:0] r_addr;

  logic            we;
  logic [IW-1:0]   waddr;
  logic [WW-1:0]   wdata;
  logic [IW-1:0]   raddr;
  logic [WW-1:0]   rdata;
  logic [EW-1:0]   rd_start;
  logic [EW-1:0]   rd_len;
  logic [EW-1:0]   prev_end;
  logic [EW-1:0]   cur_size;
  logic [EW-1:0]   cur_addr;
  logic [EW-1:0]   req_end;
  logic [EW-1:0]   pool_cap;

  assign rd_start = rdata[WW-1:EW];
  assign rd_len   = rdata[EW-1:0];
  assign prev_end = prev_start + prev_len;
  assign cur_size = EW'(cur.size);
  assign cur_addr = EW'(cur.address);
  assign req_end  = cur_addr + cur_size;
  assign pool_cap = (EW'(cfg_pool) > SPAN) ? SPAN : EW'(cfg_pool);

  ffca_ram #(.WIDTH(WW), .DEPTH(MAX_SEGMENTS)) u_seg (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // read address follows the scan index, or the shift index while moving entries
  always_comb begin
    raddr = idx[IW-1:0];
    if (state == S_DEC) begin
      raddr = sidx[IW-1:0];
    end
  end

  assign cfg_ready = (state == S_IDLE);
  assign req_ready = (state == S_IDLE) && !need_clear && !cfg_we;
  assign rsp_valid = (state == S_RESP);
  assign rsp.status = r_status;
  assign rsp.alloc_address = r_addr;
  assign rsp.free_bytes = total[SIZE_W-1:0];

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pool       <= SPAN;
      need_clear <= 1'b1;
      count      <= '0;
      total      <= '0;
      we         <= 1'b0;
    end else begin
      we <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            // a new pool size rebuilds the table from the capped pool size
            pool       <= pool_cap;
            we         <= 1'b1;
            waddr      <= '0;
            wdata      <= {EW'(0), pool_cap};
            count      <= (pool_cap != '0) ? CW'(1) : CW'(0);
            total      <= pool_cap;
            need_clear <= 1'b0;
          end else if (need_clear) begin
            we         <= 1'b1;
            waddr      <= '0;
            wdata      <= {EW'(0), pool};
            count      <= (pool != '0) ? CW'(1) : CW'(0);
            total      <= pool;
            need_clear <= 1'b0;
          end else if (req_valid) begin
            cur        <= req;
            idx        <= '0;
            prev_ok    <= 1'b0;
            prev_start <= '0;
            prev_len   <= '0;
            r_addr     <= '0;
            state      <= S_READ;
          end
        end
        // wait for the ram read of entry idx
        S_READ: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (cur.func == FUNC_ALLOC) begin
            if (idx >= count) begin
              r_status <= ST_NO_FIT;
              state    <= S_RESP;
            end else if (rd_len >= cur_size) begin
              r_status <= ST_OK;
              r_addr   <= rd_start[ADDR_W-1:0];
              total    <= total - cur_size;
              if (rd_len > cur_size) begin
                // take the low end of the segment
                we    <= 1'b1;
                waddr <= idx[IW-1:0];
                wdata <= {rd_start + cur_size, rd_len - cur_size};
                state <= S_RESP;
              end else begin
                // exact fit drops the entry
                sidx      <= idx + CW'(1);
                shift_up  <= 1'b0;
                add_count <= 1'b0;
                state     <= (idx + CW'(1) >= count) ? S_WRITE : S_DEC;
              end
            end else begin
              idx   <= idx + CW'(1);
              state <= S_READ;
            end
          end else begin
            r_status <= ST_OK;
            if (cur.size == '0) begin
              state <= S_RESP;
            end else if (req_end > pool) begin
              r_status <= ST_OVERLAP;
              state    <= S_RESP;
            end else if (idx < count && rd_start < cur_addr) begin
              prev_ok    <= 1'b1;
              prev_start <= rd_start;
              prev_len   <= rd_len;
              idx        <= idx + CW'(1);
              state      <= S_READ;
            end else begin
              nxt_start <= rd_start;
              nxt_len   <= rd_len;
              state     <= S_PREV;
            end
          end
        end
        // free decision at insertion point idx
        S_PREV: begin
          r_status <= ST_OK;
          if ((prev_ok && prev_end > cur_addr) ||
              (idx < count && req_end > nxt_start)) begin
            r_status <= ST_OVERLAP;
            state    <= S_RESP;
          end else if (prev_ok && prev_end == cur_addr &&
                       idx < count && req_end == nxt_start) begin
            // merge both: extend previous, then drop entry idx
            total     <= total + cur_size;
            we        <= 1'b1;
            waddr     <= IW'(idx - CW'(1));
            wdata     <= {prev_start, prev_len + cur_size + nxt_len};
            sidx      <= idx + CW'(1);
            shift_up  <= 1'b0;
            add_count <= 1'b0;
            state     <= (idx + CW'(1) >= count) ? S_WRITE : S_DEC;
          end else if (prev_ok && prev_end == cur_addr) begin
            total <= total + cur_size;
            we    <= 1'b1;
            waddr <= IW'(idx - CW'(1));
            wdata <= {prev_start, prev_len + cur_size};
            state <= S_RESP;
          end else if (idx < count && req_end == nxt_start) begin
            total <= total + cur_size;
            we    <= 1'b1;
            waddr <= idx[IW-1:0];
            wdata <= {cur_addr, nxt_len + cur_size};
            state <= S_RESP;
          end else if (count >= MAXC) begin
            r_status <= ST_FULL;
            state    <= S_RESP;
          end else begin
            // new segment: open a gap at idx
            total     <= total + cur_size;
            fin_data  <= {cur_addr, cur_size};
            shift_up  <= 1'b1;
            sidx      <= count - CW'(1);
            add_count <= 1'b1;
            state     <= (count == idx) ? S_WRITE : S_DEC;
          end
        end
        // read entry sidx for a shift step
        S_DEC: begin
          state <= S_SHIFT;
        end
        // rdata holds entry sidx, move it up or down by one
        S_SHIFT: begin
          we    <= 1'b1;
          wdata <= rdata;
          if (shift_up) begin
            waddr <= IW'(sidx + CW'(1));
            if (sidx == idx) begin
              state <= S_WRITE;
            end else begin
              sidx  <= sidx - CW'(1);
              state <= S_DEC;
            end
          end else begin
            waddr <= IW'(sidx - CW'(1));
            sidx  <= sidx + CW'(1);
            state <= (sidx + CW'(1) >= count) ? S_WRITE : S_DEC;
          end
        end
        // place the new entry or retire the dropped one
        S_WRITE: begin
          if (add_count) begin
            we    <= 1'b1;
            waddr <= idx[IW-1:0];
            wdata <= fin_data;
            count <= count + CW'(1);
          end else begin
            count <= count - CW'(1);
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // table never holds more than its capacity
  a_count: assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("segment count over capacity");
  // free total never exceeds the pool
  a_total: assert property (@(posedge clk) disable iff (rst) total <= pool)
    else $error("free total over pool");
  // a held result keeps its status
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(r_status))
    else $error("status changed while stalled");
  // a held result keeps its address and free total
  a_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(r_addr) && $stable(total))
    else $error("result data changed while stalled");
`endif

endmodule

>>> rtl/core/first_fit_coalescing_allocator_top.sv
// first_fit_coalescing_allocator_top: stream wrapper around the segment engine
// depends on ffca_pkg, ffca_engine
//
//  channel  dir  payload
//  cfg      in   cfg_data: pool_size
//  s_axis   in   tdata: func, address, req_size
//  m_axis   out  tdata: status, alloc_address, free_bytes
//
// one request at a time: the accept state, a read and a scan state per table entry
// examined, a decision state for a free, a read and a write state per entry moved
// by an insert or a removal and a finishing state, then the result state
// after reset the idle state rebuilds entry zero; a pool_size write is taken only
// while idle and rebuilds it as well
// the result word waits in m_axis until taken; no new word meanwhile
module first_fit_coalescing_allocator_top #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data,       // pool_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // func, address[20], req_size[21], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status[2], alloc_address[20], free_bytes[21]
);
  import ffca_pkg::*;

  req_t req;
  rsp_t rsp;
  logic [SIZE_W+1:0] rounded;

  // round size up to a multiple of four
  assign rounded = (23'(s_axis_tdata[41:21]) + 23'd3) & ~23'd3;
  assign req.func = s_axis_tdata[0];
  assign req.address = s_axis_tdata[20:1];
  assign req.size = rounded;

  ffca_engine #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_eng (
    .clk(clk), .rst(rst), .cfg_we(cfg_valid), .cfg_ready(cfg_ready), .cfg_pool(cfg_data),
    .req_valid(s_axis_tvalid), .req_ready(s_axis_tready), .req(req),
    .rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp(rsp)
  );

  assign m_axis_tdata = {5'd0, rsp.free_bytes, rsp.alloc_address, rsp.status};

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for first_fit_coalescing_allocator_top
// depends on ffca_pkg and the allocator rtl; predicts each result word in a scoreboard class

class alloc_scoreboard;
  // predicted free-segment table
  bit [22:0] seg_start[64];
  bit [22:0] seg_len[64];
  int        seg_count;
  bit [22:0] pool_bytes;
  bit [22:0] free_sum;

  // expected result words, oldest first
  ffca_pkg::status_t want_status[$];
  bit [19:0]         want_addr[$];
  bit [20:0]         want_free[$];

  // blocks currently handed out, usable for well-formed frees
  bit [22:0] live_addr[$];
  bit [22:0] live_len[$];

  int errors;

  function void set_pool(bit [20:0] value);
    pool_bytes = (value > 21'h100000) ? 23'h100000 : {2'b0, value};
    seg_start[0] = 0;
    seg_len[0] = pool_bytes;
    seg_count = (pool_bytes != 0) ? 1 : 0;
    free_sum = pool_bytes;
    live_addr.delete();
    live_len.delete();
  endfunction

  function void drop_seg(int k);
    for (int j = k; j + 1 < seg_count; j++) begin
      seg_start[j] = seg_start[j+1];
      seg_len[j] = seg_len[j+1];
    end
    seg_count--;
  endfunction

  function ffca_pkg::status_t take_block(bit [22:0] size, output bit [22:0] addr);
    addr = 0;
    for (int k = 0; k < seg_count; k++) begin
      if (seg_len[k] >= size) begin
        addr = seg_start[k];
        if (seg_len[k] > size) begin
          seg_start[k] += size;
          seg_len[k] -= size;
        end else begin
          drop_seg(k);
        end
        free_sum -= size;
        return ffca_pkg::ST_OK;
      end
    end
    return ffca_pkg::ST_NO_FIT;
  endfunction

  function ffca_pkg::status_t give_back(bit [22:0] addr, bit [22:0] size);
    int i;
    bit [22:0] last;
    bit has_prev, has_next, touch_prev, touch_next;
    i = 0;
    last = addr + size;
    if (size == 0) return ffca_pkg::ST_OK;
    if (last > pool_bytes) return ffca_pkg::ST_OVERLAP;
    while (i < seg_count && seg_start[i] < addr) i++;
    has_prev = (i > 0);
    has_next = (i < seg_count);
    if (has_prev && seg_start[i-1] + seg_len[i-1] > addr) return ffca_pkg::ST_OVERLAP;
    if (has_next && last > seg_start[i]) return ffca_pkg::ST_OVERLAP;
    touch_prev = has_prev && (seg_start[i-1] + seg_len[i-1] == addr);
    touch_next = has_next && (last == seg_start[i]);
    if (touch_prev && touch_next) begin
      seg_len[i-1] += size + seg_len[i];
      drop_seg(i);
    end else if (touch_prev) begin
      seg_len[i-1] += size;
    end else if (touch_next) begin
      seg_start[i] = addr;
      seg_len[i] += size;
    end else begin
      if (seg_count >= 64) return ffca_pkg::ST_FULL;
      for (int j = seg_count; j > i; j--) begin
        seg_start[j] = seg_start[j-1];
        seg_len[j] = seg_len[j-1];
      end
      seg_start[i] = addr;
      seg_len[i] = size;
      seg_count++;
    end
    free_sum += size;
    return ffca_pkg::ST_OK;
  endfunction

  // accepted request word: predict its result
  function void note_request(logic op, bit [19:0] addr, bit [20:0] req);
    bit [22:0] size;
    bit [22:0] got;
    ffca_pkg::status_t st;
    size = ({2'b0, req} + 23'd3) & ~23'd3;
    got = 0;
    if (op == ffca_pkg::FUNC_ALLOC) begin
      st = take_block(size, got);
      if (st != ffca_pkg::ST_OK) got = 0;
      else if (size != 0) begin
        live_addr.push_back(got);
        live_len.push_back(size);
      end
    end else begin
      st = give_back({3'b0, addr}, size);
    end
    want_status.push_back(st);
    want_addr.push_back(got[19:0]);
    want_free.push_back(free_sum[20:0]);
  endfunction

  // accepted result word: compare with the oldest prediction
  function void check_result(logic [47:0] word);
    bit fail;
    if (want_status.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word %h", word);
      return;
    end
    fail = (word[1:0] != want_status[0]) || (word[21:2] != want_addr[0]) ||
           (word[42:22] != want_free[0]);
    if (fail) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: status %0d/%0d addr %h/%h free %0d/%0d (expected/actual)",
                 want_status[0], word[1:0], want_addr[0], word[21:2],
                 want_free[0], word[42:22]);
    end
    void'(want_status.pop_front());
    void'(want_addr.pop_front());
    void'(want_free.pop_front());
  endfunction
endclass

module tb;
  import ffca_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [20:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // func, address[20], req_size[21], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // status[2], alloc_address[20], free_bytes[21]

  alloc_scoreboard sb;
  bit quiet;
  int hold_req;
  int hold_ack;
  int hold_left;

  first_fit_coalescing_allocator_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // result receiver with random stalls and requested long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      hold_ack <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // run limit
  initial begin
    #20ms;
    $display("first_fit_coalescing_allocator_top regression: fail");
    $finish;
  end

  task automatic send_req(logic op, bit [19:0] addr, bit [20:0] req);
    if (!quiet && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, req, addr, op};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(op, addr, req);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.want_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_pool(bit [20:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_pool(value);
  endtask

  // free a random live block whole
  task automatic free_live();
    int k;
    bit [22:0] a, n;
    k = $urandom_range(sb.live_addr.size() - 1);
    a = sb.live_addr[k];
    n = sb.live_len[k];
    sb.live_addr.delete(k);
    sb.live_len.delete(k);
    send_req(FUNC_FREE, a[19:0], n[20:0] - ($urandom_range(1) ? 21'd0 : 21'd3));
  endtask

  task automatic random_phase(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3 && n < count / 2);
      r = $urandom_range(99);
      if (n == 10) hold_req++;
      if (n == count / 2 + 20) wait_drained();
      if (r < 45 || sb.live_addr.size() == 0) begin
        if ($urandom_range(19) == 0)
          send_req(FUNC_ALLOC, 20'($urandom), 21'($urandom));
        else
          send_req(FUNC_ALLOC, 20'($urandom), 21'($urandom_range(0, 300)));
      end else if (r < 88) begin
        free_live();
      end else begin
        send_req(FUNC_FREE, 20'($urandom),
                 21'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(64)));
      end
    end
    quiet = 0;
  endtask

  initial begin
    bit [22:0] all;
    clk = 0;
    rst = 1;
    cfg_valid = 0;
    cfg_data = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    quiet = 0;
    hold_req = 0;
    sb = new();
    sb.errors = 0;
    sb.set_pool(21'h100000);
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: extremes and special cases on the full pool
    send_req(FUNC_ALLOC, 20'hFFFFF, 21'd0);
    send_req(FUNC_ALLOC, 20'h0, 21'h1FFFFF);
    send_req(FUNC_ALLOC, 20'h0, 21'd5);
    send_req(FUNC_FREE, 20'hFFFFF, 21'd0);
    send_req(FUNC_FREE, 20'hFFFFF, 21'd4);
    send_req(FUNC_FREE, 20'd100, 21'd4);
    send_req(FUNC_FREE, 20'd0, 21'd8);
    send_req(FUNC_ALLOC, 20'h0, 21'd16);
    all = sb.free_sum;
    send_req(FUNC_ALLOC, 20'h0, all[20:0]);
    send_req(FUNC_ALLOC, 20'h0, 21'd4);
    send_req(FUNC_FREE, 20'd0, 21'd16);
    send_req(FUNC_FREE, 20'd16, 21'hFFFF0);

    // empty pool
    write_pool(21'd0);
    send_req(FUNC_ALLOC, 20'h0, 21'd0);
    send_req(FUNC_FREE, 20'h0, 21'd4);
    send_req(FUNC_FREE, 20'h0, 21'd0);

    // register value above the address span is capped
    write_pool(21'h1FFFFF);
    send_req(FUNC_ALLOC, 20'h0, 21'h100000);
    send_req(FUNC_FREE, 20'h0, 21'h100000);

    // fragment a small pool until the segment table is full
    write_pool(21'd1024);
    for (int k = 0; k < 140; k++) send_req(FUNC_ALLOC, 20'h0, 21'd4);
    for (int k = 1; k < 140; k += 2) send_req(FUNC_FREE, 20'(k * 4), 21'd4);

    // random phases over several pool sizes
    write_pool(21'd4096);
    random_phase(130);
    write_pool(21'd65535);
    random_phase(130);
    write_pool(21'h100000);
    random_phase(130);

    wait_drained();
    repeat (400) @(posedge clk);
    if (sb.errors == 0)
      $display("first_fit_coalescing_allocator_top regression: pass");
    else
      $display("first_fit_coalescing_allocator_top regression: fail");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/ffca_pkg.sv
rtl/core/ffca_ram.sv
rtl/core/ffca_engine.sv
rtl/core/first_fit_coalescing_allocator_top.sv
tb/tb.sv
